### hdl/assert_macros.svh
// ----------------------------------------------------------------------------
// assert_macros.svh
// Concurrent assertion shorthands shared by the RTL.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check on every rising edge, suspended while reset is high.
`define ASSERT_CLKRST(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Check on every rising edge, reset included.
`define ASSERT_CLK(label, clk, prop, msg) \
   label: assert property (@(posedge clk) prop) else $error(msg);

`endif

### hdl/nsd_pkg.sv
// ----------------------------------------------------------------------------
// nsd_pkg
// Types and constants of the netstring deframer.
// ----------------------------------------------------------------------------
package nsd_pkg;

   // Parser phase
   typedef enum logic [1:0] {
      PH_PREFIX  = 2'd0,
      PH_PAYLOAD = 2'd1,
      PH_COMMA   = 2'd2
   } phase_type;

   // Result kind
   typedef enum logic [1:0] {
      KIND_BYTE  = 2'd0,
      KIND_DONE  = 2'd1,
      KIND_ERROR = 2'd2
   } kind_type;

   // Error codes
   typedef enum logic [1:0] {
      ERR_PREFIX = 2'd0,
      ERR_ZERO   = 2'd1,
      ERR_LONG   = 2'd2,
      ERR_COMMA  = 2'd3
   } err_type;

   localparam logic [7:0] CH_COLON = 8'h3A;
   localparam logic [7:0] CH_COMMA = 8'h2C;
   localparam logic [7:0] CH_ZERO  = 8'h30;
   localparam logic [7:0] CH_NINE  = 8'h39;

   localparam int FRAME_LEN_WIDTH = 16;
   localparam int MAX_LEN_WIDTH   = 16;

   // Register file
   localparam int CSR_ADDR_WIDTH = 3;
   localparam int CSR_DATA_WIDTH = 32;
   localparam logic [CSR_ADDR_WIDTH-1:0] CSR_MAX_LENGTH_ADDR = 3'd0;
   localparam logic [MAX_LEN_WIDTH-1:0]  MAX_LENGTH_RESET    = 16'hFFFF;

   // One result item
   typedef struct packed {
      kind_type                   kind;
      logic [7:0]                 out_byte;
      err_type                    error_code;
      logic [FRAME_LEN_WIDTH-1:0] frame_length;
      logic                       last;
   } rsp_type;

endpackage

### hdl/nsd_csr.sv
// ----------------------------------------------------------------------------
// nsd_csr
// APB register file holding the maximum payload length.
// ----------------------------------------------------------------------------
module nsd_csr (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                csr_psel,
   input  logic                                csr_penable,
   input  logic                                csr_pwrite,
   input  logic [nsd_pkg::CSR_ADDR_WIDTH-1:0]  csr_paddr,
   input  logic [nsd_pkg::CSR_DATA_WIDTH-1:0]  csr_pwdata,
   output logic [nsd_pkg::CSR_DATA_WIDTH-1:0]  csr_prdata,
   output logic                                csr_pready,
   output logic [nsd_pkg::MAX_LEN_WIDTH-1:0]   max_length
);

   logic [nsd_pkg::MAX_LEN_WIDTH-1:0] max_length_ff;
   logic [nsd_pkg::MAX_LEN_WIDTH-1:0] max_length_in;
   logic                              wr_max;

   assign csr_pready = 1'b1;
   assign wr_max     = csr_psel && csr_penable && csr_pwrite && csr_pready &&
                       (csr_paddr == nsd_pkg::CSR_MAX_LENGTH_ADDR);

   always_comb begin
      max_length_in = max_length_ff;
      if (wr_max) begin
         max_length_in = csr_pwdata[nsd_pkg::MAX_LEN_WIDTH-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         max_length_ff <= nsd_pkg::MAX_LENGTH_RESET;
      end else begin
         max_length_ff <= max_length_in;
      end
   end

   always_comb begin
      csr_prdata = '0;
      if (csr_paddr == nsd_pkg::CSR_MAX_LENGTH_ADDR) begin
         csr_prdata = nsd_pkg::CSR_DATA_WIDTH'(max_length_ff);
      end
   end

   assign max_length = max_length_ff;

endmodule

### hdl/nsd_parser.sv
// ----------------------------------------------------------------------------
// nsd_parser
// Netstring parse state machine: one byte in, at most one result out.
// ----------------------------------------------------------------------------
module nsd_parser #(
   parameter int LEN_WIDTH = 16
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              accept,
   input  logic [7:0]                        in_byte,
   input  logic [nsd_pkg::MAX_LEN_WIDTH-1:0] max_length,
   output logic                              res_push,
   output nsd_pkg::rsp_type                  res_data
);

   localparam int VW = LEN_WIDTH + 4;
   localparam int CW = (VW > nsd_pkg::MAX_LEN_WIDTH) ? VW : nsd_pkg::MAX_LEN_WIDTH;

   nsd_pkg::phase_type   phase_ff, phase_in;
   logic [LEN_WIDTH-1:0] length_ff, length_in;
   logic [LEN_WIDTH-1:0] left_ff, left_in;
   logic                 seen_ff, seen_in;

   logic [VW-1:0]        lv_ext;
   logic [VW-1:0]        next_value;
   logic                 too_long;
   logic                 is_digit;
   logic [LEN_WIDTH-1:0] left_dec;
   logic                 has_res;

   // length * 10 + digit, one spare nibble to see overflow
   assign lv_ext     = VW'(length_ff);
   assign next_value = (lv_ext << 3) + (lv_ext << 1) + VW'(in_byte[3:0]);
   assign too_long   = (CW'(next_value) > CW'(max_length)) ||
                       (next_value[VW-1:LEN_WIDTH] != '0);
   assign is_digit   = (in_byte >= nsd_pkg::CH_ZERO) && (in_byte <= nsd_pkg::CH_NINE);
   assign left_dec   = left_ff - LEN_WIDTH'(1);

   always_comb begin
      phase_in  = phase_ff;
      length_in = length_ff;
      left_in   = left_ff;
      seen_in   = seen_ff;
      has_res   = 1'b0;
      res_data  = '{kind:         nsd_pkg::KIND_BYTE,
                    out_byte:     8'h00,
                    error_code:   nsd_pkg::ERR_PREFIX,
                    frame_length: '0,
                    last:         1'b0};
      unique case (phase_ff)
         nsd_pkg::PH_PAYLOAD: begin
            left_in           = left_dec;
            has_res           = 1'b1;
            res_data.out_byte = in_byte;
            if (left_dec == '0) begin
               phase_in = nsd_pkg::PH_COMMA;
            end
         end
         nsd_pkg::PH_COMMA: begin
            has_res       = 1'b1;
            res_data.last = 1'b1;
            phase_in      = nsd_pkg::PH_PREFIX;
            length_in     = '0;
            left_in       = '0;
            seen_in       = 1'b0;
            if (in_byte == nsd_pkg::CH_COMMA) begin
               res_data.kind         = nsd_pkg::KIND_DONE;
               res_data.frame_length = nsd_pkg::FRAME_LEN_WIDTH'(length_ff);
            end else begin
               res_data.kind       = nsd_pkg::KIND_ERROR;
               res_data.error_code = nsd_pkg::ERR_COMMA;
            end
         end
         default: begin
            if (is_digit && !too_long) begin
               length_in = next_value[LEN_WIDTH-1:0];
               seen_in   = 1'b1;
            end else if (in_byte == nsd_pkg::CH_COLON && seen_ff && length_ff != '0) begin
               left_in  = length_ff;
               phase_in = nsd_pkg::PH_PAYLOAD;
            end else begin
               // any fault: report and restart the prefix
               has_res       = 1'b1;
               res_data.kind = nsd_pkg::KIND_ERROR;
               res_data.last = 1'b1;
               phase_in      = nsd_pkg::PH_PREFIX;
               length_in     = '0;
               left_in       = '0;
               seen_in       = 1'b0;
               if (is_digit) begin
                  res_data.error_code = nsd_pkg::ERR_LONG;
               end else if (in_byte == nsd_pkg::CH_COLON && seen_ff) begin
                  res_data.error_code = nsd_pkg::ERR_ZERO;
               end else begin
                  res_data.error_code = nsd_pkg::ERR_PREFIX;
               end
            end
         end
      endcase
   end

   assign res_push = accept && has_res;

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff  <= nsd_pkg::PH_PREFIX;
         length_ff <= '0;
         left_ff   <= '0;
         seen_ff   <= 1'b0;
      end else if (accept) begin
         phase_ff  <= phase_in;
         length_ff <= length_in;
         left_ff   <= left_in;
         seen_ff   <= seen_in;
      end
   end

endmodule

### hdl/nsd_out_buf.sv
// ----------------------------------------------------------------------------
// nsd_out_buf
// Two-entry output register with skid stage; ready depends on fill only.
// ----------------------------------------------------------------------------
module nsd_out_buf (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  nsd_pkg::rsp_type push_data,
   output logic             space,
   output logic             out_valid,
   input  logic             out_ready,
   output nsd_pkg::rsp_type out_data
);

   logic             out_valid_ff, out_valid_in;
   logic             skid_valid_ff, skid_valid_in;
   nsd_pkg::rsp_type out_data_ff, out_data_in;
   nsd_pkg::rsp_type skid_data_ff, skid_data_in;
   logic             take;

   assign take  = out_valid_ff && out_ready;
   assign space = !skid_valid_ff;

   always_comb begin
      out_valid_in  = out_valid_ff;
      skid_valid_in = skid_valid_ff;
      out_data_in   = out_data_ff;
      skid_data_in  = skid_data_ff;
      if (skid_valid_ff) begin
         if (take) begin
            out_data_in   = skid_data_ff;
            skid_valid_in = 1'b0;
         end
      end else if (push) begin
         if (!out_valid_ff || take) begin
            out_data_in  = push_data;
            out_valid_in = 1'b1;
         end else begin
            // output stalled: park in the skid stage
            skid_data_in  = push_data;
            skid_valid_in = 1'b1;
         end
      end else if (take) begin
         out_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff  <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else begin
         out_valid_ff  <= out_valid_in;
         skid_valid_ff <= skid_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      out_data_ff  <= out_data_in;
      skid_data_ff <= skid_data_in;
   end

   assign out_valid = out_valid_ff;
   assign out_data  = out_data_ff;

endmodule

### hdl/netstring_deframer.sv
// ----------------------------------------------------------------------------
// netstring_deframer
// Byte-serial netstring deframer with APB-programmable maximum length.
//
// The block takes one byte per clock on req_ and parses "<digits>:<payload>,".
// Payload bytes come out on rsp_ one by one (tuser = byte kind); the comma
// produces a frame-complete result carrying the length, and any framing fault
// produces an error result, both with tlast high, after which parsing restarts
// at the length prefix. Results are registered in the output buffer. Throughput
// is one byte per cycle: the parse state updates as each byte is taken and
// results pass through a two-entry output buffer, so req_tready stays high
// unless both entries are full. No clearing pass is needed after reset.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module netstring_deframer #(
   parameter int LEN_WIDTH = 16
) (
   input  logic                                clock,
   input  logic                                reset,
   // input stream
   input  logic                                req_tvalid,
   output logic                                req_tready,
   input  logic [7:0]                          req_tdata,  // [7:0] in_byte
   // result stream
   output logic                                rsp_tvalid,
   input  logic                                rsp_tready,
   output logic [31:0]                         rsp_tdata,  // [7:0] out_byte,
                                                            // [9:8] error_code,
                                                            // [25:10] frame_length
   output logic [1:0]                          rsp_tuser,  // [1:0] kind
   output logic                                rsp_tlast,
   // register port
   input  logic                                csr_psel,
   input  logic                                csr_penable,
   input  logic                                csr_pwrite,
   input  logic [nsd_pkg::CSR_ADDR_WIDTH-1:0]  csr_paddr,
   input  logic [nsd_pkg::CSR_DATA_WIDTH-1:0]  csr_pwdata,
   output logic [nsd_pkg::CSR_DATA_WIDTH-1:0]  csr_prdata,
   output logic                                csr_pready
);

   logic [nsd_pkg::MAX_LEN_WIDTH-1:0] max_length;
   logic                              accept;
   logic                              res_push;
   logic                              buf_space;
   nsd_pkg::rsp_type                  res_data;
   nsd_pkg::rsp_type                  out_data;

   assign req_tready = buf_space;
   assign accept     = req_tvalid && req_tready;

   nsd_csr u_csr (
      .clock       (clock),
      .reset       (reset),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready),
      .max_length  (max_length)
   );

   nsd_parser #(
      .LEN_WIDTH (LEN_WIDTH)
   ) u_parser (
      .clock      (clock),
      .reset      (reset),
      .accept     (accept),
      .in_byte    (req_tdata),
      .max_length (max_length),
      .res_push   (res_push),
      .res_data   (res_data)
   );

   nsd_out_buf u_out_buf (
      .clock     (clock),
      .reset     (reset),
      .push      (res_push),
      .push_data (res_data),
      .space     (buf_space),
      .out_valid (rsp_tvalid),
      .out_ready (rsp_tready),
      .out_data  (out_data)
   );

   assign rsp_tdata = {6'b0, out_data.frame_length, out_data.error_code, out_data.out_byte};
   assign rsp_tuser = out_data.kind;
   assign rsp_tlast = out_data.last;

   `ASSERT_CLKRST(a_last_marks_end, clock, reset,
      rsp_tvalid |-> (rsp_tlast == (rsp_tuser != nsd_pkg::KIND_BYTE)),
      "tlast does not match result kind")

   `ASSERT_CLKRST(a_error_fields_clear, clock, reset,
      (rsp_tvalid && rsp_tuser == nsd_pkg::KIND_ERROR) |->
         (out_data.out_byte == 8'h00 && out_data.frame_length == '0),
      "error result carries payload or length")

   `ASSERT_CLKRST(a_max_length_held, clock, reset,
      !(csr_psel && csr_penable && csr_pwrite) |=> $stable(max_length),
      "max_length changed without a register write")

   `ASSERT_CLK(a_reset_empties, clock,
      reset |=> !rsp_tvalid && req_tready,
      "output buffer not empty after reset")

endmodule
